/* rtl/log_pa_pkg.sv */
// Shared types and constants for the fixed-point logarithm pipeline.
// No dependencies; imported by log_pa_horner and log_polynomial_approx_top.
`default_nettype none
package log_pa_pkg;

    localparam int OUT_FRAC_BITS = 24;
    localparam int RND_SHIFT     = 30 - OUT_FRAC_BITS;
    localparam logic signed [41:0] RND_HALF =
        (RND_SHIFT == 0) ? 42'sd0 : 42'(64'sd1 <<< (RND_SHIFT - 1));

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_NEG  = 2'd2;
    localparam logic [1:0] ST_NAN  = 2'd3;

    localparam logic [1:0] OP_LOG2  = 2'd0;
    localparam logic [1:0] OP_LN    = 2'd1;
    localparam logic [1:0] OP_LOG10 = 2'd2;

    // Polynomial coefficients in Q2.30, index = power of m
    localparam logic signed [33:0] COEF [0:9] = '{
        34'sd41847,
        34'sd1548455218,
        -34'sd770271440,
        34'sd498810890,
        -34'sd338473290,
        34'sd211929306,
        -34'sd109536388,
        34'sd41792917,
        -34'sd10175665,
        34'sd1168428
    };

    localparam logic [29:0] LN2_Q30  = 30'd744261118;
    localparam logic [29:0] LG2_Q30  = 30'd323228497;

    typedef struct packed {
        logic [31:0] float_bits;
        logic [1:0]  opcode;
    } in_t;

    typedef struct packed {
        logic signed [32:0] log_value;
        logic [1:0]         status;
    } out_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         op;
        logic signed [8:0]  e;
        logic [23:0]        m;
        logic signed [33:0] acc;
    } item_t;

endpackage
`default_nettype wire

/* rtl/log_pa_horner.sv */
// One registered Horner step: acc <= rnd(acc * m >> 24) + coef.
// Depends on log_pa_pkg.
`default_nettype none
module log_pa_horner (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire log_pa_pkg::item_t         in_item,
    input  wire logic signed [33:0]        coef,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output log_pa_pkg::item_t              out_item
);
    import log_pa_pkg::*;

    logic               valid_reg;
    item_t              item_reg;
    item_t              item_next;
    logic signed [58:0] prod;
    logic signed [58:0] prod_rnd;

    always_comb
    begin
        prod      = in_item.acc * $signed({1'b0, in_item.m});
        // round half away from zero
        prod_rnd  = prod + 59'sd8388608 - {58'd0, prod[58]};
        item_next = in_item;
        item_next.acc = prod_rnd[57:24] + coef;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

endmodule
`default_nettype wire

/* rtl/log_polynomial_approx_top.sv */
// Fixed-point logarithm of an IEEE single: decode, nine Horner stages, scale, round.
// Depends on log_pa_pkg and log_pa_horner.
//
// Input channel in_valid/in_ready/in_data carries the float bits and the base
// opcode (log2, ln, log10; the unused code acts as log2). Output channel
// out_valid/out_ready/out_data carries the signed result with OUT_FRAC_BITS
// fraction bits and a status code; zero, negative, infinity and NaN inputs
// return status with a zero value.
// From acceptance to out_valid a transaction passes one decode stage, nine
// Horner stages (one multiplier each), a sum stage, a split-multiply scaling
// stage and the rounding/saturation output register.
// Throughput is one transaction per cycle while out_ready does not stall the
// pipe. Every stage has its own valid bit and advances when empty or when
// the stage after it advances, so bubbles are filled and a stalled receiver
// only backs the pipe up stage by stage; no transaction is lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
`default_nettype none
module log_polynomial_approx_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire log_pa_pkg::in_t   in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output log_pa_pkg::out_t       out_data
);
    import log_pa_pkg::*;

    // decode stage
    logic        dec_valid_reg;
    item_t       dec_item_reg;
    item_t       dec_item_next;
    logic        dec_ready;
    logic [7:0]  ef;
    logic [22:0] frac;
    logic [4:0]  lz;
    logic [23:0] frac_sh;

    always_comb
    begin
        ef   = in_data.float_bits[30:23];
        frac = in_data.float_bits[22:0];
        lz   = 5'd22;
        for (int i = 0; i < 23; i++)
        begin
            if (frac[i])
                lz = 5'(22 - i);
        end
        frac_sh = {1'b0, frac} << (lz + 5'd1);

        dec_item_next.op  = (in_data.opcode == OP_LN || in_data.opcode == OP_LOG10)
                            ? in_data.opcode : OP_LOG2;
        dec_item_next.acc = COEF[9];
        if (ef != 8'd0)
        begin
            dec_item_next.e = $signed({1'b0, ef}) - 9'sd127;
            dec_item_next.m = {frac, 1'b0};
        end
        else
        begin
            dec_item_next.e = -9'sd127 - $signed({4'd0, lz});
            dec_item_next.m = {frac_sh[22:0], 1'b0};
        end
        priority if (ef == 8'hFF)
            dec_item_next.status = ST_NAN;
        else if (ef == 8'd0 && frac == 23'd0)
            dec_item_next.status = ST_ZERO;
        else if (in_data.float_bits[31])
            dec_item_next.status = ST_NEG;
        else
            dec_item_next.status = ST_OK;
    end

    // Horner chain
    logic  h_valid [0:9];
    logic  h_ready [0:9];
    item_t h_item  [0:9];

    assign h_valid[0] = dec_valid_reg;
    assign h_item[0]  = dec_item_reg;
    assign dec_ready  = !dec_valid_reg || h_ready[0];
    assign in_ready   = dec_ready;

    for (genvar k = 0; k < 9; k++)
    begin : g_horner
        log_pa_horner u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (h_valid[k]),
            .in_ready  (h_ready[k]),
            .in_item   (h_item[k]),
            .coef      (COEF[8 - k]),
            .out_valid (h_valid[k + 1]),
            .out_ready (h_ready[k + 1]),
            .out_item  (h_item[k + 1])
        );
    end

    // sum stage: L = E * 2^30 + p
    logic               sum_valid_reg;
    logic               sum_ready;
    logic signed [40:0] sum_reg;
    logic [1:0]         sum_status_reg;
    logic [1:0]         sum_op_reg;
    logic signed [40:0] sum_next;

    assign sum_next   = $signed({{2{h_item[9].e[8]}}, h_item[9].e, 30'd0})
                        + 41'(h_item[9].acc);
    assign h_ready[9] = sum_ready;

    // scaling multiply stage, split into high and low partial products
    logic               mul_valid_reg;
    logic               mul_ready;
    logic [39:0]        phi_reg;
    logic [59:0]        plo_reg;
    logic               mul_neg_reg;
    logic               mul_scale_reg;
    logic signed [40:0] mul_sum_reg;
    logic [1:0]         mul_status_reg;
    logic [39:0]        mag;
    logic [29:0]        kmul;

    assign sum_ready = !sum_valid_reg || mul_ready;
    assign mag  = sum_reg[40] ? 40'(-sum_reg) : sum_reg[39:0];
    assign kmul = (sum_op_reg == OP_LN) ? LN2_Q30 : LG2_Q30;

    // output stage
    logic               out_valid_reg;
    out_t               out_data_reg;
    out_t               out_next;
    logic [40:0]        r_mag;
    logic signed [41:0] scaled;
    logic signed [41:0] rounded;
    logic signed [41:0] shifted;

    assign mul_ready = !mul_valid_reg || !out_valid_reg || out_ready;

    always_comb
    begin
        r_mag = 41'(phi_reg) + 41'((plo_reg + 60'd536870912) >> 30);
        if (mul_scale_reg)
            scaled = mul_neg_reg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
        else
            scaled = 42'(mul_sum_reg);
        rounded = scaled + RND_HALF
                  - ((RND_SHIFT != 0 && scaled[41]) ? 42'sd1 : 42'sd0);
        shifted = rounded >>> RND_SHIFT;
        out_next.status = mul_status_reg;
        priority if (mul_status_reg != ST_OK)
            out_next.log_value = 33'sd0;
        else if (shifted > 42'sd4294967295)
            out_next.log_value = 33'sh0FFFFFFFF;
        else if (shifted < -42'sd4294967296)
            out_next.log_value = 33'sh100000000;
        else
            out_next.log_value = shifted[32:0];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (dec_ready)
                dec_valid_reg <= in_valid;
            if (sum_ready)
                sum_valid_reg <= h_valid[9];
            if (mul_ready)
                mul_valid_reg <= sum_valid_reg;
            if (!out_valid_reg || out_ready)
                out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_ready && in_valid)
            dec_item_reg <= dec_item_next;
        if (sum_ready && h_valid[9])
        begin
            sum_reg        <= sum_next;
            sum_status_reg <= h_item[9].status;
            sum_op_reg     <= h_item[9].op;
        end
        if (mul_ready && sum_valid_reg)
        begin
            phi_reg        <= 40'(mag[39:30] * kmul);
            plo_reg        <= mag[29:0] * kmul;
            mul_neg_reg    <= sum_reg[40];
            mul_scale_reg  <= (sum_op_reg == OP_LN) || (sum_op_reg == OP_LOG10);
            mul_sum_reg    <= sum_reg;
            mul_status_reg <= sum_status_reg;
        end
        if ((!out_valid_reg || out_ready) && mul_valid_reg)
            out_data_reg <= out_next;
    end

    // flagged inputs never carry a value
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.log_value == 33'sd0)
        else $error("nonzero status with nonzero value");

    // a stalled decode stage keeps its transaction
    a_dec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid_reg && !h_ready[0] |=> dec_valid_reg && $stable(dec_item_reg))
        else $error("decode stage lost a stalled transaction");

    // a stalled scaling stage keeps its products
    a_mul_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mul_valid_reg && !mul_ready |=> mul_valid_reg && $stable(plo_reg)
        && $stable(phi_reg))
        else $error("scaling stage lost a stalled transaction");

endmodule
`default_nettype wire
